FILE: rtl/cbf_pkg.sv
// ----------------------------------------------------------------------------
// cbf_pkg: shared types and constants for the comment blanking filter
// Character codes, queue entry types and the blanking helper used by both
// the block-comment front stage and the line-comment back stage.
// ----------------------------------------------------------------------------
package cbf_pkg;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // default depth of each inter-stage queue
    localparam int CBF_FIFO_DEPTH = 4;

    // one byte in flight, tagged with the end-of-text mark
    typedef struct packed {
        logic [7:0] byte_val;
        logic       end_flag;
    } t_entry;

    // up to two bytes written into a queue in one cycle; lane 1 only with lane 0
    typedef struct packed {
        logic   vld0;
        logic   vld1;
        t_entry d0;
        t_entry d1;
    } t_pair;

    // comment byte replacement: newline survives, everything else blanks
    function automatic logic [7:0] f_blank(input logic [7:0] c);
        return (c == CH_NL) ? CH_NL : CH_SPACE;
    endfunction

endpackage

FILE: rtl/cbf_fifo.sv
// ----------------------------------------------------------------------------
// cbf_fifo: small register queue, two writes and one read per cycle
// Decouples the stages; o_room2 reports space for a two-byte write.
// ----------------------------------------------------------------------------
module cbf_fifo
    import cbf_pkg::*;
#(
    parameter int DEPTH = CBF_FIFO_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_pair  i_push,
    output logic   o_room2,
    output logic   o_rd_valid,
    output t_entry o_rd_data,
    input  logic   i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

    t_entry          r_mem [DEPTH];
    logic [PW-1:0]   r_wp, n_wp, r_rp, n_rp, w_wp1;
    logic [CW-1:0]   r_count, n_count;
    logic [1:0]      w_n_push;
    logic            w_pop;

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    assign w_wp1      = f_inc(r_wp);
    assign w_pop      = i_pop && (r_count != '0);
    assign w_n_push   = {1'b0, i_push.vld0} + {1'b0, i_push.vld1};
    assign o_room2    = (r_count <= ROOM_MAX);
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rp];

    always_comb begin
        n_wp = r_wp;
        if (i_push.vld1) begin
            n_wp = f_inc(w_wp1);
        end else if (i_push.vld0) begin
            n_wp = w_wp1;
        end
        n_rp    = w_pop ? f_inc(r_rp) : r_rp;
        n_count = r_count + CW'(w_n_push) - CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld0) begin
            r_mem[r_wp] <= i_push.d0;
        end
        if (i_push.vld1) begin
            r_mem[w_wp1] <= i_push.d1;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.vld0 |-> o_room2)
        else $error("write without room for two");
    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !i_push.vld0) |=> (r_count == $past(r_count) - 1'b1))
        else $error("read did not drop the count");
`endif

endmodule

FILE: rtl/cbf_block_stage.sv
// ----------------------------------------------------------------------------
// cbf_block_stage: front stage, control-byte mapping and block comments
// Accepts raw bytes, blanks slash-star comments and writes 0 to 2 bytes
// per transaction into the front queue.
// ----------------------------------------------------------------------------
module cbf_block_stage
    import cbf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_text_byte,
    input  logic       i_text_end,
    input  logic       i_room2,
    output logic       o_stall,
    output t_pair      o_push
);

    logic       r_block_mode, n_block_mode;
    logic       r_star, n_star;
    logic       r_held_vld, n_held_vld;
    logic [7:0] r_held, n_held;
    logic       w_acc;
    logic [7:0] w_c;

    assign w_acc   = i_valid && i_room2;
    assign o_stall = !i_room2;
    assign w_c     = (i_text_byte < CH_NL) ? CH_SPACE : i_text_byte;

    always_comb begin
        o_push       = '0;
        n_block_mode = r_block_mode;
        n_star       = r_star;
        n_held_vld   = r_held_vld;
        n_held       = r_held;
        if (w_acc) begin
            if (r_block_mode) begin
                o_push.vld0        = 1'b1;
                o_push.d0.end_flag = i_text_end;
                if (r_star && (w_c == CH_SLASH)) begin
                    o_push.d0.byte_val = CH_SPACE;
                    n_block_mode       = 1'b0;
                    n_star             = 1'b0;
                end else begin
                    o_push.d0.byte_val = f_blank(w_c);
                    n_star             = (w_c == CH_STAR);
                end
            end else if (r_held_vld && (r_held == CH_SLASH) && (w_c == CH_STAR)) begin
                // opener: both bytes blank, then search for the closer
                o_push.vld0 = 1'b1;
                o_push.vld1 = 1'b1;
                o_push.d0   = '{byte_val: CH_SPACE, end_flag: 1'b0};
                o_push.d1   = '{byte_val: CH_SPACE, end_flag: i_text_end};
                n_held_vld   = 1'b0;
                n_block_mode = 1'b1;
                n_star       = 1'b0;
            end else if (r_held_vld) begin
                o_push.vld0 = 1'b1;
                o_push.d0   = '{byte_val: r_held, end_flag: 1'b0};
                n_held      = w_c;
                n_held_vld  = 1'b1;
                if (i_text_end) begin
                    o_push.vld1 = 1'b1;
                    o_push.d1   = '{byte_val: w_c, end_flag: 1'b1};
                end
            end else begin
                n_held     = w_c;
                n_held_vld = 1'b1;
                if (i_text_end) begin
                    o_push.vld0 = 1'b1;
                    o_push.d0   = '{byte_val: w_c, end_flag: 1'b1};
                end
            end
            // end of text: flush done above, start the next text clean
            if (i_text_end) begin
                n_block_mode = 1'b0;
                n_star       = 1'b0;
                n_held_vld   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_mode <= 1'b0;
            r_star       <= 1'b0;
            r_held_vld   <= 1'b0;
        end else begin
            r_block_mode <= n_block_mode;
            r_star       <= n_star;
            r_held_vld   <= n_held_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

`ifndef SYNTHESIS
    a_mode_no_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_block_mode |-> !r_held_vld)
        else $error("held byte inside block comment");
    a_star_in_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_block_mode |-> !r_star)
        else $error("star armed outside block comment");
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_text_end) |=> (!r_block_mode && !r_held_vld))
        else $error("state left over after end of text");
`endif

endmodule

FILE: rtl/cbf_line_stage.sv
// ----------------------------------------------------------------------------
// cbf_line_stage: back stage, line comments
// Reads one byte per cycle from the front queue while the output queue has
// room, blanks slash-slash comments up to the newline and writes 0 to 2 bytes to the output queue.
// ----------------------------------------------------------------------------
module cbf_line_stage
    import cbf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  t_entry i_in_data,
    input  logic   i_room2,
    output logic   o_pop,
    output t_pair  o_push
);

    logic       r_line_mode, n_line_mode;
    logic       r_held_vld, n_held_vld;
    logic [7:0] r_held, n_held;
    logic [7:0] w_c;
    logic       w_end;

    assign o_pop = i_in_valid && i_room2;
    assign w_c   = i_in_data.byte_val;
    assign w_end = i_in_data.end_flag;

    always_comb begin
        o_push      = '0;
        n_line_mode = r_line_mode;
        n_held_vld  = r_held_vld;
        n_held      = r_held;
        if (o_pop) begin
            if (r_line_mode) begin
                o_push.vld0 = 1'b1;
                o_push.d0   = '{byte_val: f_blank(w_c), end_flag: w_end};
                n_line_mode = (w_c != CH_NL);
            end else if (r_held_vld && (r_held == CH_SLASH) && (w_c == CH_SLASH)) begin
                o_push.vld0 = 1'b1;
                o_push.vld1 = 1'b1;
                o_push.d0   = '{byte_val: CH_SPACE, end_flag: 1'b0};
                o_push.d1   = '{byte_val: CH_SPACE, end_flag: w_end};
                n_held_vld  = 1'b0;
                n_line_mode = 1'b1;
            end else if (r_held_vld) begin
                o_push.vld0 = 1'b1;
                o_push.d0   = '{byte_val: r_held, end_flag: 1'b0};
                n_held      = w_c;
                n_held_vld  = 1'b1;
                if (w_end) begin
                    o_push.vld1 = 1'b1;
                    o_push.d1   = '{byte_val: w_c, end_flag: 1'b1};
                end
            end else begin
                n_held     = w_c;
                n_held_vld = 1'b1;
                if (w_end) begin
                    o_push.vld0 = 1'b1;
                    o_push.d0   = '{byte_val: w_c, end_flag: 1'b1};
                end
            end
            if (w_end) begin
                n_line_mode = 1'b0;
                n_held_vld  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_mode <= 1'b0;
            r_held_vld  <= 1'b0;
        end else begin
            r_line_mode <= n_line_mode;
            r_held_vld  <= n_held_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

`ifndef SYNTHESIS
    a_mode_no_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_mode |-> !r_held_vld)
        else $error("held byte inside line comment");
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && w_end) |=> (!r_line_mode && !r_held_vld))
        else $error("state left over after end of text");
    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && w_end) |-> o_push.vld0)
        else $error("end of text produced no byte");
`endif

endmodule

FILE: rtl/comment_blanking_filter_unit.sv
// ----------------------------------------------------------------------------
// comment_blanking_filter_unit: streaming comment blanker for source text
// Input channel: i_valid / o_stall carry i_text_byte and i_text_end; a
// transaction completes on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry o_clean_byte and o_clean_end.
// Every byte of a text comes out once, in order; comment bytes turn into
// spaces (newlines kept), bytes 0 to 9 into spaces; o_clean_end marks the
// final byte of a text, so bytes in == bytes out per text.
// Throughput: one transaction per cycle on each side, sustained while the
// receiver does not stall; each queue reads one entry per cycle, which sets that figure.
// Lookahead: each stage holds one byte, so a byte normally waits
// for the next byte of the text (or i_text_end). A byte that neither stage
// holds is written to the front queue, then to the output queue, and is
// on o_valid once it is in the output queue, when both queues are empty.
// Reset: synchronous, active low; both queues empty, both stages return to
// the outside-comment state with nothing held.
// Receiver stall: the output queue fills, the back stage halts, the front
// queue fills and o_stall rises; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module comment_blanking_filter_unit
    import cbf_pkg::*;
#(
    parameter int FIFO_DEPTH = CBF_FIFO_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_text_end,
    // output channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_clean_byte,
    output logic       o_clean_end
);

    // front stage to front queue
    t_pair  w_front_push;
    logic   w_front_room2;
    // front queue to back stage
    logic   w_front_rd_valid;
    t_entry w_front_rd_data;
    logic   w_front_pop;
    // back stage to output queue
    t_pair  w_back_push;
    logic   w_back_room2;
    t_entry w_out_data;
    logic   w_out_pop;

    // Classify bytes and blank block comments
    cbf_block_stage u_block (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_text_byte (i_text_byte),
        .i_text_end  (i_text_end),
        .i_room2     (w_front_room2),
        .o_stall     (o_stall),
        .o_push      (w_front_push)
    );

    cbf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_front_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_front_push),
        .o_room2    (w_front_room2),
        .o_rd_valid (w_front_rd_valid),
        .o_rd_data  (w_front_rd_data),
        .i_pop      (w_front_pop)
    );

    // Blank line comments; advance only when the output queue has room
    cbf_line_stage u_line (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (w_front_rd_valid),
        .i_in_data  (w_front_rd_data),
        .i_room2    (w_back_room2),
        .o_pop      (w_front_pop),
        .o_push     (w_back_push)
    );

    // Output queue doubles as the skid stage toward the receiver
    cbf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_back_push),
        .o_room2    (w_back_room2),
        .o_rd_valid (o_valid),
        .o_rd_data  (w_out_data),
        .i_pop      (w_out_pop)
    );

    // drop the head entry once the receiver takes it
    assign w_out_pop    = o_valid && !i_stall;
    assign o_clean_byte = w_out_data.byte_val;
    assign o_clean_end  = w_out_data.end_flag;

endmodule
